>>> hw/rtl/lcr_pkg.sv
// lcr_pkg: shared types and constants of the line and circle rasterizer
// holds command and shape codes, the queued job record and the pixel record
// no dependencies; imported by every rasterizer module
package lcr_pkg;

	// coordinate width of the input fields
	localparam int COORD_BITS = 12;
	// signed pixel coordinate width
	localparam int XY_W = COORD_BITS + 2;
	// line delta width
	localparam int DELTA_W = COORD_BITS + 1;
	// bresenham error width
	localparam int ERR_W = COORD_BITS + 4;
	// midpoint decision width
	localparam int DEC_W = COORD_BITS + 6;

	// midpoint circle constants
	localparam int CIRC_DEC_INIT = 3;
	localparam int CIRC_INC_A = 6;
	localparam int CIRC_INC_AB = 10;

	// configuration widths
	localparam int PITCH_W = 16;
	localparam int BPP_W = 4;
	localparam int SIZE_W = 13;
	localparam int CFG_IDX_W = 2;
	localparam int ADDR_W = 32;

	// reset values of the configuration registers
	localparam logic [PITCH_W-1:0] PITCH_RST = 16'd2048;
	localparam logic [BPP_W-1:0] BPP_RST = 4'd4;
	localparam logic [SIZE_W-1:0] WIDTH_RST = 13'd512;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd512;

	// job queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// number of pixels of one circle step
	localparam int CIRC_PIX = 8;
	localparam int PIX_IDX_W = $clog2(CIRC_PIX);

	// stream widths
	localparam int S_TDATA_W = 88;
	localparam int M_TDATA_W = 88;

	typedef enum logic [1:0] {
		CMD_LINE   = 2'd0,
		CMD_CIRCLE = 2'd1,
		CMD_STEP   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		SHAPE_IDLE   = 2'd0,
		SHAPE_LINE   = 2'd1,
		SHAPE_CIRCLE = 2'd2
	} shape_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_PITCH = 2'd0,
		CFG_BPP       = 2'd1,
		CFG_WIDTH     = 2'd2,
		CFG_HEIGHT    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	// one input item
	typedef struct packed {
		logic [1:0]            cmd;
		logic [COORD_BITS-1:0] a_x;
		logic [COORD_BITS-1:0] a_y;
		logic [COORD_BITS-1:0] b_x;
		logic [COORD_BITS-1:0] b_y;
		logic [COORD_BITS-1:0] radius;
		color_t                color;
	} cmd_item_t;

	// configuration seen by the back part
	typedef struct packed {
		logic [PITCH_W-1:0] pitch;
		logic [BPP_W-1:0]   bpp;
		logic [SIZE_W-1:0]  width;
		logic [SIZE_W-1:0]  height;
	} cfg_t;

	// one step of work: a line pixel or a circle octant position
	typedef struct packed {
		logic                   is_circle;
		logic signed [XY_W-1:0] px;
		logic signed [XY_W-1:0] py;
		logic [COORD_BITS-1:0]  ofs_a;
		logic [COORD_BITS-1:0]  ofs_b;
		logic                   done;
		color_t                 color;
	} job_t;

	// one result item
	typedef struct packed {
		logic                   visible;
		logic [ADDR_W-1:0]      addr;
		logic signed [XY_W-1:0] px;
		logic signed [XY_W-1:0] py;
		color_t                 color;
		logic                   last;
		logic                   done;
	} pix_t;

endpackage

>>> hw/rtl/lcr_queue.sv
// lcr_queue: short job queue between the rasterizer front and back parts
// depends on lcr_pkg for the job record and the queue depth
module lcr_queue import lcr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic empty,
	output job_t head
);

	job_t                entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QPTR_W:0]     cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entry_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= push_job;
	end

endmodule

>>> hw/rtl/lcr_front.sv
// lcr_front: accepts items, loads shapes and advances bresenham/midpoint state
// depends on lcr_pkg; pushes one job per productive step into lcr_queue
module lcr_front import lcr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  cmd_item_t in_item,
	input  logic      q_full,
	output logic      push,
	output job_t      push_job
);

	shape_t                   shape_q, shape_d;
	logic signed [XY_W-1:0]   cur_x_q, cur_y_q, cur_x_d, cur_y_d;
	logic signed [XY_W-1:0]   tgt_x_q, tgt_y_q, tgt_x_d, tgt_y_d;
	logic signed [XY_W-1:0]   ctr_x_q, ctr_y_q, ctr_x_d, ctr_y_d;
	logic [DELTA_W-1:0]       dx_q, dy_q, dx_d, dy_d;
	logic [1:0]               sgn_q, sgn_d;
	logic signed [ERR_W-1:0]  err_q, err_d;
	logic signed [DEC_W-1:0]  dec_q, dec_d;
	color_t                   color_q, color_d;

	logic                     accept;
	logic                     is_step;
	logic                     line_end;
	logic                     mv_x, mv_y;
	logic signed [ERR_W-1:0]  err_dx, err_dy;
	logic signed [XY_W-1:0]   step_x, step_y;
	logic                     circ_over;
	logic signed [XY_W-1:0]   circ_a_n, circ_b_n;
	logic                     circ_done;
	logic signed [DEC_W-1:0]  dec_step;
	logic [DELTA_W-1:0]       ld_dx, ld_dy;
	logic signed [ERR_W-1:0]  ld_err;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_step  = accept && (in_item.cmd == CMD_STEP);

	// line step terms
	assign line_end = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
	assign err_dx   = $signed(ERR_W'(dx_q));
	assign err_dy   = $signed(ERR_W'(dy_q));
	assign mv_x     = err_q > -err_dx;
	assign mv_y     = err_q < err_dy;
	assign step_x   = sgn_q[0] ? -XY_W'(1) : XY_W'(1);
	assign step_y   = sgn_q[1] ? -XY_W'(1) : XY_W'(1);

	// circle step terms, cursor holds the octant offsets
	assign circ_over = cur_x_q > cur_y_q;
	assign circ_a_n  = cur_x_q + XY_W'(1);
	assign circ_b_n  = dec_q[DEC_W-1] ? cur_y_q : cur_y_q - XY_W'(1);
	assign circ_done = circ_a_n > circ_b_n;
	assign dec_step  = dec_q[DEC_W-1] ?
		(DEC_W'(cur_x_q) <<< 2) + DEC_W'(CIRC_INC_A) :
		((DEC_W'(cur_x_q) - DEC_W'(cur_y_q)) <<< 2) + DEC_W'(CIRC_INC_AB);

	// line load terms
	assign ld_dx  = (in_item.b_x > in_item.a_x) ? DELTA_W'(in_item.b_x - in_item.a_x) :
	                                              DELTA_W'(in_item.a_x - in_item.b_x);
	assign ld_dy  = (in_item.b_y > in_item.a_y) ? DELTA_W'(in_item.b_y - in_item.a_y) :
	                                              DELTA_W'(in_item.a_y - in_item.b_y);
	assign ld_err = (ld_dx > ld_dy) ? $signed(ERR_W'(ld_dx >> 1)) :
	                                  -$signed(ERR_W'(ld_dy >> 1));

	// next shape
	always_comb begin
		shape_d = shape_q;
		if (accept) begin
			case (in_item.cmd)
				CMD_LINE:   shape_d = SHAPE_LINE;
				CMD_CIRCLE: shape_d = (in_item.radius == '0) ? SHAPE_IDLE : SHAPE_CIRCLE;
				CMD_STEP: begin
					case (shape_q)
						SHAPE_LINE:   shape_d = line_end ? SHAPE_IDLE : SHAPE_LINE;
						SHAPE_CIRCLE: shape_d = (circ_over || circ_done) ? SHAPE_IDLE
						                                                : SHAPE_CIRCLE;
						default:      shape_d = shape_q;
					endcase
				end
				default:    shape_d = shape_q;
			endcase
		end
	end

	// job push to the queue
	always_comb begin
		push_job.is_circle = (shape_q == SHAPE_CIRCLE);
		push_job.px        = push_job.is_circle ? ctr_x_q : cur_x_q;
		push_job.py        = push_job.is_circle ? ctr_y_q : cur_y_q;
		push_job.ofs_a     = COORD_BITS'(cur_x_q);
		push_job.ofs_b     = COORD_BITS'(cur_y_q);
		push_job.done      = push_job.is_circle ? circ_done : line_end;
		push_job.color     = color_q;
		case (shape_q)
			SHAPE_LINE:   push = is_step;
			SHAPE_CIRCLE: push = is_step && !circ_over;
			default:      push = 1'b0;
		endcase
	end

	// next shape data
	always_comb begin
		cur_x_d = cur_x_q;
		cur_y_d = cur_y_q;
		tgt_x_d = tgt_x_q;
		tgt_y_d = tgt_y_q;
		ctr_x_d = ctr_x_q;
		ctr_y_d = ctr_y_q;
		dx_d    = dx_q;
		dy_d    = dy_q;
		sgn_d   = sgn_q;
		err_d   = err_q;
		dec_d   = dec_q;
		color_d = color_q;
		if (accept) begin
			case (in_item.cmd)
				CMD_LINE: begin
					cur_x_d = XY_W'(in_item.a_x);
					cur_y_d = XY_W'(in_item.a_y);
					tgt_x_d = XY_W'(in_item.b_x);
					tgt_y_d = XY_W'(in_item.b_y);
					dx_d    = ld_dx;
					dy_d    = ld_dy;
					sgn_d   = {!(in_item.a_y < in_item.b_y), !(in_item.a_x < in_item.b_x)};
					err_d   = ld_err;
					color_d = in_item.color;
				end
				CMD_CIRCLE: begin
					color_d = in_item.color;
					if (in_item.radius != '0) begin
						ctr_x_d = XY_W'(in_item.a_x);
						ctr_y_d = XY_W'(in_item.a_y);
						cur_x_d = '0;
						cur_y_d = XY_W'(in_item.radius);
						dec_d   = DEC_W'(CIRC_DEC_INIT) - (DEC_W'(in_item.radius) << 1);
					end
				end
				CMD_STEP: begin
					if (shape_q == SHAPE_LINE && !line_end) begin
						err_d = err_q - (mv_x ? err_dy : '0) + (mv_y ? err_dx : '0);
						if (mv_x)
							cur_x_d = cur_x_q + step_x;
						if (mv_y)
							cur_y_d = cur_y_q + step_y;
					end else if (shape_q == SHAPE_CIRCLE && !circ_over) begin
						dec_d   = dec_q + dec_step;
						cur_x_d = circ_a_n;
						cur_y_d = circ_b_n;
					end
				end
				default: ;
			endcase
		end
	end

	// shape state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			shape_q <= SHAPE_IDLE;
		else
			shape_q <= shape_d;
	end

	// shape data, only read while a shape is loaded
	always_ff @(posedge clk) begin
		cur_x_q <= cur_x_d;
		cur_y_q <= cur_y_d;
		tgt_x_q <= tgt_x_d;
		tgt_y_q <= tgt_y_d;
		ctr_x_q <= ctr_x_d;
		ctr_y_q <= ctr_y_d;
		dx_q    <= dx_d;
		dy_q    <= dy_d;
		sgn_q   <= sgn_d;
		err_q   <= err_d;
		dec_q   <= dec_d;
		color_q <= color_d;
	end

endmodule

>>> hw/rtl/lcr_back.sv
// lcr_back: expands queued jobs into pixels, clips them and forms byte addresses
// depends on lcr_pkg; reads jobs from lcr_queue, drives the result register
module lcr_back import lcr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic q_empty,
	input  job_t q_head,
	output logic q_pop,
	output logic out_valid,
	input  logic out_ready,
	output pix_t out_pix
);

	logic                   adv;
	logic [PIX_IDX_W-1:0]   k_q;
	logic                   finish;
	logic [COORD_BITS-1:0]  ofs_u, ofs_v;
	logic signed [XY_W-1:0] gen_x, gen_y;

	logic                   v_s1;
	logic signed [XY_W-1:0] px_s1, py_s1;
	logic                   last_s1, done_s1;
	color_t                 color_s1;

	logic                   vis_c;
	logic                   v_s2;
	logic                   vis_s2;
	logic [PITCH_W+SIZE_W-1:0] prod_y_s2;
	logic [BPP_W+SIZE_W-1:0]   prod_x_s2;
	logic signed [XY_W-1:0] px_s2, py_s2;
	logic                   last_s2, done_s2;
	color_t                 color_s2;

	logic                   v_q;
	pix_t                   pix_q;

	// whole pipe moves when the result register is free or taken
	assign adv    = !v_q || out_ready;
	assign finish = !q_head.is_circle || (k_q == PIX_IDX_W'(CIRC_PIX - 1));
	assign q_pop  = adv && !q_empty && finish;

	// octant mirror: k[1] swaps offsets, k[0] negates x, k[2] picks lower half
	assign ofs_u = k_q[1] ? q_head.ofs_b : q_head.ofs_a;
	assign ofs_v = k_q[1] ? q_head.ofs_a : q_head.ofs_b;
	always_comb begin
		if (q_head.is_circle) begin
			gen_x = k_q[0] ? q_head.px - $signed(XY_W'(ofs_u)) : q_head.px + $signed(XY_W'(ofs_u));
			gen_y = k_q[2] ? q_head.py + $signed(XY_W'(ofs_v)) : q_head.py - $signed(XY_W'(ofs_v));
		end else begin
			gen_x = q_head.px;
			gen_y = q_head.py;
		end
	end

	// clip window test, row and column 0 excluded
	assign vis_c = (px_s1 >= XY_W'(1)) && (py_s1 >= XY_W'(1)) &&
	               ($signed({px_s1[XY_W-1], px_s1}) < $signed((XY_W+1)'(cfg.width))) &&
	               ($signed({py_s1[XY_W-1], py_s1}) < $signed((XY_W+1)'(cfg.height)));

	// valid bits and pixel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else if (adv) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_q  <= v_s2;
			if (!q_empty)
				k_q <= finish ? '0 : k_q + 1'b1;
		end
	end

	// pixel stage, product stage and result register
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1    <= gen_x;
			py_s1    <= gen_y;
			last_s1  <= finish;
			done_s1  <= q_head.done;
			color_s1 <= q_head.color;

			vis_s2    <= vis_c;
			prod_y_s2 <= SIZE_W'(py_s1) * cfg.pitch;
			prod_x_s2 <= SIZE_W'(px_s1) * cfg.bpp;
			px_s2     <= px_s1;
			py_s2     <= py_s1;
			last_s2   <= last_s1;
			done_s2   <= done_s1;
			color_s2  <= color_s1;

			pix_q.visible <= vis_s2;
			pix_q.addr    <= vis_s2 ? ADDR_W'(prod_y_s2) + ADDR_W'(prod_x_s2) : '0;
			pix_q.px      <= px_s2;
			pix_q.py      <= py_s2;
			pix_q.color   <= color_s2;
			pix_q.last    <= last_s2;
			pix_q.done    <= done_s2;
		end
	end

	assign out_valid = v_q;
	assign out_pix   = pix_q;

endmodule

>>> hw/rtl/line_circle_rasterizer_top.sv
// line_circle_rasterizer_top: stream ports, configuration registers and wiring
// depends on lcr_pkg, lcr_front, lcr_queue and lcr_back
//
// Usage:
//   s_* carries command items: load line, load circle (radius 0 leaves it idle)
//   or step. Loads give no result; a line step gives one pixel item, a circle
//   step gives eight. m_* carries pixel items with clip flag, byte address,
//   coordinates and BGR bytes; m_tlast ends each step's run.
//   cfg_* writes row pitch, bytes per pixel, surface width and height; it is
//   always ready and must only be used while no item is in flight.
//   The pixel items of a step pass the job queue, then the pixel stage, the
//   product stage and the result register of the back part.
//   Throughput: the front takes one item per cycle while its 4-entry job queue
//   has room; the back emits one pixel per cycle while m_tready is high.
//   Reset clears the loaded shape, the queue and the pipeline and restores
//   the register defaults (pitch 2048, 4 bytes per pixel, 512 x 512).
//   When m_tready is low and an item waits, the back pipeline holds; the front
//   keeps taking items until the job queue fills, then drops s_tready.
module line_circle_rasterizer_top import lcr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// point_a_x, point_a_y, point_b_x, point_b_y, radius, red_in, green_in,
	// blue_in, zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	// cmd
	input  logic [1:0]           s_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PITCH_W-1:0]   cfg_data,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// byte_address, pixel_x, pixel_y, blue_out, green_out, red_out, zero pad
	output logic [M_TDATA_W-1:0] m_tdata,
	// visible, shape_done
	output logic [1:0]           m_tuser,
	output logic                 m_tlast
);

	cmd_item_t in_item;
	cfg_t      cfg_q;
	logic      q_full, q_empty, q_push, q_pop;
	job_t      push_job, q_head;
	pix_t      out_pix;

	// unpack command item
	assign in_item.cmd         = s_tuser;
	assign in_item.a_x         = s_tdata[11:0];
	assign in_item.a_y         = s_tdata[23:12];
	assign in_item.b_x         = s_tdata[35:24];
	assign in_item.b_y         = s_tdata[47:36];
	assign in_item.radius      = s_tdata[59:48];
	assign in_item.color.red   = s_tdata[67:60];
	assign in_item.color.green = s_tdata[75:68];
	assign in_item.color.blue  = s_tdata[83:76];

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pitch  <= PITCH_RST;
			cfg_q.bpp    <= BPP_RST;
			cfg_q.width  <= WIDTH_RST;
			cfg_q.height <= HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROW_PITCH: cfg_q.pitch  <= cfg_data;
				CFG_BPP:       cfg_q.bpp    <= cfg_data[BPP_W-1:0];
				CFG_WIDTH:     cfg_q.width  <= cfg_data[SIZE_W-1:0];
				CFG_HEIGHT:    cfg_q.height <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	lcr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.q_full   (q_full),
		.push     (q_push),
		.push_job (push_job)
	);

	lcr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	lcr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pix   (out_pix)
	);

	// pack pixel item
	assign m_tdata = {4'b0000, out_pix.color.red, out_pix.color.green, out_pix.color.blue,
	                  out_pix.py, out_pix.px, out_pix.addr};
	assign m_tuser = {out_pix.done, out_pix.visible};
	assign m_tlast = out_pix.last;

endmodule

>>> sim/testbench.sv
// testbench: self-checking bench for line_circle_rasterizer_top
// predicts each pixel item of bresenham lines and midpoint circles, checks the stream
// depends on lcr_pkg and the rasterizer rtl
module testbench;
	import lcr_pkg::*;

	// command code that the block must ignore
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// cycles without any handshake before the run is declared hung
	localparam int QUIET_LIMIT = 4000;
	// settle time after the last expected pixel item
	localparam int SETTLE_CYCLES = 16;

	// predicts the pixel items of each accepted command item and checks the output
	class pixel_predictor;
		pix_t expected_pixels[$];
		int failures;
		int pitch, bpp, width, height;
		shape_t shape;
		int cur_x, cur_y, end_x, end_y, dx, dy, err, ctr_x, ctr_y, dec;
		logic [1:0] signs;
		color_t color;

		function new();
			failures = 0;
			pitch = PITCH_RST;
			bpp = BPP_RST;
			width = WIDTH_RST;
			height = HEIGHT_RST;
			shape = SHAPE_IDLE;
			cur_x = 0; cur_y = 0; end_x = 0; end_y = 0;
			dx = 0; dy = 0; err = 0; ctr_x = 0; ctr_y = 0; dec = 0;
			signs = 2'b00;
			color = '0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [PITCH_W-1:0] val);
			case (idx)
				CFG_ROW_PITCH: pitch = val;
				CFG_BPP:       bpp = val[BPP_W-1:0];
				CFG_WIDTH:     width = val[SIZE_W-1:0];
				CFG_HEIGHT:    height = val[SIZE_W-1:0];
				default: ;
			endcase
		endfunction

		// clip flag, byte address and color of one pixel
		function void add_pixel(int x, int y, logic last, logic done);
			pix_t p;
			logic [63:0] addr;
			logic vis;
			vis = x >= 1 && x <= width - 1 && y >= 1 && y <= height - 1;
			addr = vis ? longint'(y) * longint'(pitch) + longint'(x) * longint'(bpp) : 64'd0;
			p.visible = vis;
			p.addr = addr[ADDR_W-1:0];
			p.px = x[XY_W-1:0];
			p.py = y[XY_W-1:0];
			p.color = color;
			p.last = last;
			p.done = done;
			expected_pixels.push_back(p);
		endfunction

		function void note_command(cmd_item_t it);
			int x0, y0, x1, y1, e2, a, b;
			logic done;
			x0 = int'(it.a_x);
			y0 = int'(it.a_y);
			x1 = int'(it.b_x);
			y1 = int'(it.b_y);
			case (it.cmd)
				CMD_LINE: begin
					dx = x1 > x0 ? x1 - x0 : x0 - x1;
					dy = y1 > y0 ? y1 - y0 : y0 - y1;
					signs = {y0 >= y1, x0 >= x1};
					err = dx > dy ? dx / 2 : -(dy / 2);
					cur_x = x0; cur_y = y0;
					end_x = x1; end_y = y1;
					color = it.color;
					shape = SHAPE_LINE;
				end
				CMD_CIRCLE: begin
					color = it.color;
					if (it.radius == 0) begin
						shape = SHAPE_IDLE;
					end else begin
						ctr_x = x0;
						ctr_y = y0;
						cur_x = 0;
						cur_y = int'(it.radius);
						dec = 3 - 2 * cur_y;
						shape = SHAPE_CIRCLE;
					end
				end
				CMD_STEP: begin
					if (shape == SHAPE_LINE) begin
						// end pixel closes the line
						if (cur_x == end_x && cur_y == end_y) begin
							add_pixel(cur_x, cur_y, 1'b1, 1'b1);
							shape = SHAPE_IDLE;
						end else begin
							add_pixel(cur_x, cur_y, 1'b1, 1'b0);
							e2 = err;
							if (e2 > -dx) begin
								err -= dy;
								cur_x += signs[0] ? -1 : 1;
							end
							if (e2 < dy) begin
								err += dx;
								cur_y += signs[1] ? -1 : 1;
							end
						end
					end else if (shape == SHAPE_CIRCLE) begin
						a = cur_x;
						b = cur_y;
						if (a > b) begin
							shape = SHAPE_IDLE;
						end else begin
							// midpoint decision update, then eight mirrored pixels
							if (dec < 0) begin
								dec += a * 4 + 6;
							end else begin
								dec += (a - b) * 4 + 10;
								cur_y = b - 1;
							end
							cur_x = a + 1;
							done = cur_x > cur_y;
							add_pixel(ctr_x + a, ctr_y - b, 1'b0, done);
							add_pixel(ctr_x - a, ctr_y - b, 1'b0, done);
							add_pixel(ctr_x + b, ctr_y - a, 1'b0, done);
							add_pixel(ctr_x - b, ctr_y - a, 1'b0, done);
							add_pixel(ctr_x + a, ctr_y + b, 1'b0, done);
							add_pixel(ctr_x - a, ctr_y + b, 1'b0, done);
							add_pixel(ctr_x + b, ctr_y + a, 1'b0, done);
							add_pixel(ctr_x - b, ctr_y + a, 1'b1, done);
							if (done)
								shape = SHAPE_IDLE;
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				failures++;
			end
		endfunction

		function void check_pixel(pix_t got);
			pix_t want;
			if (expected_pixels.size() == 0) begin
				$error("pixel item with none expected: x %0d, y %0d", got.px, got.py);
				failures++;
				return;
			end
			want = expected_pixels.pop_front();
			compare_field("visible", want.visible, got.visible);
			compare_field("byte_address", want.addr, got.addr);
			compare_field("pixel_x", longint'(want.px), longint'(got.px));
			compare_field("pixel_y", longint'(want.py), longint'(got.py));
			compare_field("blue_out", want.color.blue, got.color.blue);
			compare_field("green_out", want.color.green, got.color.green);
			compare_field("red_out", want.color.red, got.color.red);
			compare_field("last", want.last, got.last);
			compare_field("shape_done", want.done, got.done);
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid;
	logic s_tready;
	// point_a_x, point_a_y, point_b_x, point_b_y, radius, red_in, green_in,
	// blue_in, zero pad
	logic [S_TDATA_W-1:0] s_tdata;
	// cmd
	logic [1:0] s_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PITCH_W-1:0] cfg_data;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// byte_address, pixel_x, pixel_y, blue_out, green_out, red_out, zero pad
	logic [M_TDATA_W-1:0] m_tdata;
	// visible, shape_done
	logic [1:0] m_tuser;
	logic m_tlast;

	pixel_predictor sb = new();
	logic gaps_on = 1'b1;
	int quiet_cycles = 0;

	line_circle_rasterizer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// clock, period 4
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		m_tready <= !gaps_on || $urandom_range(99) >= 32;
	end

	// watch every handshake at the rising edge
	always @(posedge clk) begin
		cmd_item_t cmd_in;
		pix_t pix_out;
		if (arst_n) begin
			quiet_cycles++;
			if (cfg_valid && cfg_ready) begin
				sb.set_reg(cfg_idx_t'(cfg_index), cfg_data);
				quiet_cycles = 0;
			end
			if (s_tvalid && s_tready) begin
				cmd_in.cmd = s_tuser;
				cmd_in.a_x = s_tdata[11:0];
				cmd_in.a_y = s_tdata[23:12];
				cmd_in.b_x = s_tdata[35:24];
				cmd_in.b_y = s_tdata[47:36];
				cmd_in.radius = s_tdata[59:48];
				cmd_in.color.red = s_tdata[67:60];
				cmd_in.color.green = s_tdata[75:68];
				cmd_in.color.blue = s_tdata[83:76];
				sb.note_command(cmd_in);
				quiet_cycles = 0;
			end
			if (m_tvalid && m_tready) begin
				pix_out.visible = m_tuser[0];
				pix_out.done = m_tuser[1];
				pix_out.last = m_tlast;
				pix_out.addr = m_tdata[31:0];
				pix_out.px = m_tdata[45:32];
				pix_out.py = m_tdata[59:46];
				pix_out.color.blue = m_tdata[67:60];
				pix_out.color.green = m_tdata[75:68];
				pix_out.color.red = m_tdata[83:76];
				sb.check_pixel(pix_out);
				quiet_cycles = 0;
			end
		end
	end

	// hang detection
	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("testbench failed");
		$finish;
	end

	// send one command item, with random gaps ahead of it
	task automatic send_cmd(logic [1:0] op, int ax, int ay, int bx, int by, int r, color_t c);
		while (gaps_on && $urandom_range(99) < 32) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tuser = op;
		s_tdata = {4'b0, c.blue, c.green, c.red, r[11:0], by[11:0], bx[11:0], ay[11:0],
			ax[11:0]};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// step items carry random content in the unused fields
	task automatic step_shape(int n);
		repeat (n)
			send_cmd(CMD_STEP, $urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
				24'($urandom));
	endtask

	// hold the sender until every expected pixel item is out and the pipe is empty
	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (sb.expected_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int val);
		cfg_index = idx;
		cfg_data = val[PITCH_W-1:0];
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_surface(int pitch, int bpp, int w, int h);
		write_reg(CFG_ROW_PITCH, pitch);
		write_reg(CFG_BPP, bpp);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
	endtask

	function automatic int rand_coord();
		case ($urandom_range(9))
			0: return 0;
			1: return 4095;
			2, 3, 4, 5: return $urandom_range(0, 600);
			default: return $urandom_range(0, 4095);
		endcase
	endfunction

	// endpoint near a given point, kept in the coordinate range
	function automatic int near_coord(int c, int span);
		int v;
		v = c + $urandom_range(0, 2 * span) - span;
		return v < 0 ? 0 : (v > 4095 ? 4095 : v);
	endfunction

	// mostly loads followed by step runs, some noise and stray steps
	task automatic random_burst(int n);
		int sent, kind, ax, ay, bx, by, r, span, steps;
		sent = 0;
		while (sent < n) begin
			kind = $urandom_range(99);
			ax = rand_coord();
			ay = rand_coord();
			steps = 0;
			if (kind < 8) begin
				send_cmd(CMD_UNUSED, ax, ay, $urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095), 24'($urandom));
				sent++;
			end else if (kind < 14) begin
				steps = $urandom_range(1, 3);
			end else if (kind < 55) begin
				span = $urandom_range(9) == 0 ? 4095 : 24;
				bx = near_coord(ax, span);
				by = near_coord(ay, span);
				send_cmd(CMD_LINE, ax, ay, bx, by, $urandom_range(0, 4095), 24'($urandom));
				sent++;
				steps = $urandom_range(1, 40);
			end else begin
				case ($urandom_range(19))
					0: r = 0;
					1: r = $urandom_range(0, 4095);
					default: r = $urandom_range(1, 30);
				endcase
				send_cmd(CMD_CIRCLE, ax, ay, $urandom_range(0, 4095), $urandom_range(0, 4095),
					r, 24'($urandom));
				sent++;
				steps = $urandom_range(1, 30);
			end
			repeat (steps) begin
				if (sent < n) begin
					step_shape(1);
					sent++;
				end
			end
			if ($urandom_range(49) == 0)
				wait_idle();
		end
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_LINE;
		cfg_valid = 1'b0;
		cfg_index = CFG_ROW_PITCH;
		cfg_data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed: step while idle, ignored code, short line with its end pixel
		step_shape(1);
		send_cmd(CMD_UNUSED, 4095, 4095, 4095, 4095, 4095, 24'hFFFFFF);
		send_cmd(CMD_LINE, 0, 0, 3, 1, 0, 24'hFF00FF);
		step_shape(4);
		// zero radius leaves the engine idle
		send_cmd(CMD_CIRCLE, 100, 100, 0, 0, 0, 24'h123456);
		step_shape(1);
		// largest circle, far outside the clip window
		send_cmd(CMD_CIRCLE, 4095, 4095, 4095, 4095, 4095, 24'h00FF00);
		step_shape(2);
		// small circle near the corner, coordinates underflow below zero
		send_cmd(CMD_CIRCLE, 2, 2, 0, 0, 3, 24'($urandom));
		step_shape(3);
		// reversed diagonal, then an ignored code in the middle of it
		send_cmd(CMD_LINE, 4095, 0, 0, 4095, 0, 24'($urandom));
		step_shape(2);
		send_cmd(CMD_UNUSED, 0, 0, 0, 0, 0, 24'h000000);
		step_shape(1);
		// a load replaces the shape in progress; single-point line
		send_cmd(CMD_LINE, 5, 5, 5, 5, 0, 24'($urandom));
		step_shape(1);
		// steep line going left
		send_cmd(CMD_LINE, 10, 2, 7, 9, 0, 24'($urandom));
		step_shape(2);

		// largest row pitch, 8 bytes per pixel, 4096 x 4096 surface
		wait_idle();
		set_surface(65535, 8, 4096, 4096);
		random_burst(66);

		// smallest nonzero register values, nothing visible
		wait_idle();
		set_surface(1, 1, 1, 1);
		random_burst(40);

		// zero width and height
		wait_idle();
		set_surface($urandom_range(1, 65535), $urandom_range(1, 8), 0, 0);
		random_burst(30);

		// stretch without gaps on either side
		wait_idle();
		set_surface($urandom_range(1, 65535), $urandom_range(1, 8), $urandom_range(1, 4096),
			$urandom_range(1, 4096));
		gaps_on = 1'b0;
		random_burst(90);
		gaps_on = 1'b1;

		wait_idle();
		set_surface($urandom_range(1, 65535), $urandom_range(1, 8), $urandom_range(1, 4096),
			$urandom_range(1, 4096));
		random_burst(80);

		wait_idle();
		if (sb.failures == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
